FILE: design/nm3_pkg.sv
package nm3_pkg;

   localparam int DATA_W = 32;
   localparam int PROD_W = 64;
   localparam int COF_W = 65;
   localparam int TERM_W = 97;
   localparam int DET_W = 99;
   localparam int MAG_W = 97;
   localparam int Q_W = 32;
   localparam int N_ELEM = 9;
   localparam int N_PROD = 18;
   localparam int N_ROW = 3;
   localparam int Q_DEPTH = 2;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

   // cofactor k = p[2k] - p[2k+1]; el holds the first matrix row
   typedef struct packed {
      logic [N_PROD-1:0][PROD_W-1:0] p;
      logic [N_ROW-1:0][DATA_W-1:0]  el;
   } prod_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic [PROD_W-1:0] smul(input logic signed [DATA_W-1:0] x,
                                              input logic signed [DATA_W-1:0] y);
      logic signed [PROD_W-1:0] r;
      r = x * y;
      return r;
   endfunction

endpackage

FILE: design/nm3_if.sv
interface nm3_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] in_0;
   logic signed [31:0] in_1;
   logic signed [31:0] in_2;
   logic signed [31:0] in_4;
   logic signed [31:0] in_5;
   logic signed [31:0] in_6;
   logic signed [31:0] in_8;
   logic signed [31:0] in_9;
   logic signed [31:0] in_10;

   modport source(output valid, in_0, in_1, in_2, in_4, in_5, in_6, in_8, in_9, in_10,
                  input ready);
   modport sink(input valid, in_0, in_1, in_2, in_4, in_5, in_6, in_8, in_9, in_10,
                output ready);
endinterface

interface nm3_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] out_0;
   logic signed [31:0] out_1;
   logic signed [31:0] out_2;
   logic signed [31:0] out_3;
   logic signed [31:0] out_4;
   logic signed [31:0] out_5;
   logic signed [31:0] out_6;
   logic signed [31:0] out_7;
   logic signed [31:0] out_8;
   logic singular;

   modport source(output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
                  out_8, singular, input ready);
   modport sink(input valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
                out_8, singular, output ready);
endinterface

FILE: design/nm3_front.sv
module nm3_front (
   input  logic                 clock,
   input  logic                 reset,
   nm3_req_if.sink              req_ch,
   input  nm3_pkg::q_stat_type  q_stat,
   output logic                 push_valid,
   output nm3_pkg::prod_type    push_data
);

   logic              fv_ff, fv_in;
   nm3_pkg::prod_type prod_ff, prod_in;
   logic              take;
   logic signed [nm3_pkg::DATA_W-1:0] a, b, c, d, e, f, g, h, i;

   assign a = req_ch.in_0;
   assign b = req_ch.in_1;
   assign c = req_ch.in_2;
   assign d = req_ch.in_4;
   assign e = req_ch.in_5;
   assign f = req_ch.in_6;
   assign g = req_ch.in_8;
   assign h = req_ch.in_9;
   assign i = req_ch.in_10;

   assign req_ch.ready = !fv_ff || !q_stat.full;
   assign take = req_ch.valid && req_ch.ready;

   always_comb begin
      fv_in = take || (fv_ff && q_stat.full);
      prod_in = prod_ff;
      if (take) begin
         prod_in.p[0]  = nm3_pkg::smul(e, i);
         prod_in.p[1]  = nm3_pkg::smul(f, h);
         prod_in.p[2]  = nm3_pkg::smul(f, g);
         prod_in.p[3]  = nm3_pkg::smul(d, i);
         prod_in.p[4]  = nm3_pkg::smul(d, h);
         prod_in.p[5]  = nm3_pkg::smul(e, g);
         prod_in.p[6]  = nm3_pkg::smul(c, h);
         prod_in.p[7]  = nm3_pkg::smul(b, i);
         prod_in.p[8]  = nm3_pkg::smul(a, i);
         prod_in.p[9]  = nm3_pkg::smul(c, g);
         prod_in.p[10] = nm3_pkg::smul(b, g);
         prod_in.p[11] = nm3_pkg::smul(a, h);
         prod_in.p[12] = nm3_pkg::smul(b, f);
         prod_in.p[13] = nm3_pkg::smul(c, e);
         prod_in.p[14] = nm3_pkg::smul(c, d);
         prod_in.p[15] = nm3_pkg::smul(a, f);
         prod_in.p[16] = nm3_pkg::smul(a, e);
         prod_in.p[17] = nm3_pkg::smul(b, d);
         prod_in.el[0] = a;
         prod_in.el[1] = b;
         prod_in.el[2] = c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
      prod_ff <= prod_in;
   end

   assign push_valid = fv_ff;
   assign push_data = prod_ff;

endmodule

FILE: design/nm3_queue.sv
module nm3_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  nm3_pkg::prod_type    push_data,
   input  logic                 pop,
   output nm3_pkg::q_stat_type  q_stat,
   output nm3_pkg::prod_type    pop_data
);

   localparam int PW = $clog2(nm3_pkg::Q_DEPTH);
   localparam int CNT_W = $clog2(nm3_pkg::Q_DEPTH + 1);

   nm3_pkg::prod_type mem_ff [nm3_pkg::Q_DEPTH];
   logic [PW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              push;

   assign q_stat.full = (cnt_ff == CNT_W'(nm3_pkg::Q_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign push = push_valid && !q_stat.full;
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(nm3_pkg::Q_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == PW'(nm3_pkg::Q_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(nm3_pkg::Q_DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !q_stat.empty)
      else $error("queue empty after push");

endmodule

FILE: design/nm3_div.sv
module nm3_div (
   input  logic                                               clock,
   input  logic                                               en,
   input  logic [nm3_pkg::MAG_W-1:0]                          r_start,
   input  logic [nm3_pkg::Q_W-1:0]                            n_start,
   input  logic                                               neg_start,
   input  logic                                               sat_start,
   input  logic [nm3_pkg::Q_W-1:0][nm3_pkg::MAG_W-1:0]        dpipe,
   output logic [nm3_pkg::Q_W-1:0]                            q,
   output logic                                               neg,
   output logic                                               sat
);

   localparam int STEPS = nm3_pkg::Q_W;
   localparam int MW = nm3_pkg::MAG_W;
   localparam int QW = nm3_pkg::Q_W;

   logic [MW-1:0] r_ff [STEPS];
   logic [MW-1:0] r_in [STEPS];
   logic [QW-1:0] n_ff [STEPS];
   logic [QW-1:0] n_in [STEPS];
   logic [QW-1:0] q_ff [STEPS];
   logic [QW-1:0] q_in [STEPS];
   logic [STEPS-1:0] neg_ff, neg_in, sat_ff, sat_in;

   // one quotient bit per stage; remainder stays below the divisor
   always_comb begin
      logic [MW-1:0] r_prv;
      logic [QW-1:0] n_prv, q_prv;
      logic [MW:0]   trial, diff;
      logic          hit;
      for (int s = 0; s < STEPS; s++) begin
         if (s == 0) begin
            r_prv = r_start;
            n_prv = n_start;
            q_prv = '0;
            neg_in[s] = neg_start;
            sat_in[s] = sat_start;
         end else begin
            r_prv = r_ff[s-1];
            n_prv = n_ff[s-1];
            q_prv = q_ff[s-1];
            neg_in[s] = neg_ff[s-1];
            sat_in[s] = sat_ff[s-1];
         end
         trial = {r_prv, n_prv[QW-1]};
         diff = trial - {1'b0, dpipe[s]};
         hit = (trial >= {1'b0, dpipe[s]});
         r_in[s] = hit ? diff[MW-1:0] : trial[MW-1:0];
         n_in[s] = {n_prv[QW-2:0], 1'b0};
         q_in[s] = {q_prv[QW-2:0], hit};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
         n_ff <= n_in;
         q_ff <= q_in;
         neg_ff <= neg_in;
         sat_ff <= sat_in;
      end
   end

   assign q = q_ff[STEPS-1];
   assign neg = neg_ff[STEPS-1];
   assign sat = sat_ff[STEPS-1];

endmodule

FILE: design/nm3_back.sv
module nm3_back #(
   parameter int FRAC_BITS = nm3_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nm3_pkg::q_stat_type  q_stat,
   input  nm3_pkg::prod_type    pop_data,
   output logic                 pop,
   nm3_rsp_if.source            rsp_ch
);

   localparam int NE = nm3_pkg::N_ELEM;
   localparam int NR = nm3_pkg::N_ROW;
   localparam int CF = nm3_pkg::COF_W;
   localparam int TW = nm3_pkg::TERM_W;
   localparam int DW = nm3_pkg::DET_W;
   localparam int MW = nm3_pkg::MAG_W;
   localparam int QW = nm3_pkg::Q_W;
   localparam int PW = nm3_pkg::PROD_W;
   localparam int NW = PW + 2 * FRAC_BITS;
   localparam int CW = MW + QW;
   localparam int STEPS = nm3_pkg::Q_W;

   logic en;

   // stage 1: cofactors
   logic v1_ff;
   logic [CF-1:0] cf1_ff [NE];
   logic [CF-1:0] cf1_in [NE];
   logic [nm3_pkg::DATA_W-1:0] el1_ff [NR];
   // stage 2: partial products of first row times cofactors
   logic v2_ff;
   logic [CF-1:0] cf2_ff [NE];
   logic [CF-1:0] plo2_ff [NR];
   logic [CF-1:0] plo2_in [NR];
   logic [CF-1:0] phi2_ff [NR];
   logic [CF-1:0] phi2_in [NR];
   // stage 3: determinant terms
   logic v3_ff;
   logic [CF-1:0] cf3_ff [NE];
   logic [TW-1:0] t3_ff [NR];
   logic [TW-1:0] t3_in [NR];
   // stage 4: determinant
   logic v4_ff;
   logic [CF-1:0] cf4_ff [NE];
   logic [DW-1:0] det4_ff, det4_in;
   // stage 5: magnitudes and signs
   logic v5_ff, sing5_ff, sing5_in;
   logic [NE-1:0] neg5_ff, neg5_in;
   logic [PW-1:0] nmag5_ff [NE];
   logic [PW-1:0] nmag5_in [NE];
   logic [MW-1:0] dmag5_ff, dmag5_in;
   logic [DW-1:0] det_neg;
   // stage 6: saturation check and divider start
   logic v6_ff, sing6_ff;
   logic [NE-1:0] neg6_ff, sat6_ff, sat6_in;
   logic [MW-1:0] r06_ff [NE];
   logic [MW-1:0] r06_in [NE];
   logic [QW-1:0] nl6_ff [NE];
   logic [QW-1:0] nl6_in [NE];
   logic [MW-1:0] dmag6_ff;
   // divider stages
   logic [STEPS-1:0] vd_ff, vd_in, sd_ff, sd_in;
   logic [MW-1:0] dch_ff [STEPS-1];
   logic [MW-1:0] dch_in [STEPS-1];
   logic [STEPS-1:0][MW-1:0] dpipe;
   logic [QW-1:0] lq [NE];
   logic [NE-1:0] lneg, lsat;
   // output register
   logic ov_ff, osing_ff, osing_in;
   logic [QW-1:0] out_ff [NE];
   logic [QW-1:0] out_in [NE];

   assign en = !(ov_ff && !rsp_ch.ready);
   assign pop = en && !q_stat.empty;

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         cf1_in[k] = {pop_data.p[2*k][PW-1], pop_data.p[2*k]}
                   - {pop_data.p[2*k+1][PW-1], pop_data.p[2*k+1]};
      end
   end

   always_comb begin
      logic signed [QW:0] lo33, hi33;
      logic signed [CF-1:0] mlo, mhi;
      for (int j = 0; j < NR; j++) begin
         lo33 = $signed({1'b0, cf1_ff[j][QW-1:0]});
         hi33 = $signed(cf1_ff[j][CF-1:QW]);
         mlo = $signed(el1_ff[j]) * lo33;
         mhi = $signed(el1_ff[j]) * hi33;
         plo2_in[j] = mlo;
         phi2_in[j] = mhi;
      end
   end

   always_comb begin
      for (int j = 0; j < NR; j++) begin
         t3_in[j] = {phi2_ff[j], {QW{1'b0}}} + {{(TW-CF){plo2_ff[j][CF-1]}}, plo2_ff[j]};
      end
      det4_in = {{(DW-TW){t3_ff[0][TW-1]}}, t3_ff[0]}
              + {{(DW-TW){t3_ff[1][TW-1]}}, t3_ff[1]}
              + {{(DW-TW){t3_ff[2][TW-1]}}, t3_ff[2]};
   end

   always_comb begin
      logic [CF-1:0] cneg;
      det_neg = -det4_ff;
      sing5_in = (det4_ff == '0);
      dmag5_in = det4_ff[DW-1] ? det_neg[MW-1:0] : det4_ff[MW-1:0];
      for (int k = 0; k < NE; k++) begin
         cneg = -cf4_ff[k];
         neg5_in[k] = cf4_ff[k][CF-1] ^ det4_ff[DW-1];
         nmag5_in[k] = cf4_ff[k][CF-1] ? cneg[PW-1:0] : cf4_ff[k][PW-1:0];
      end
   end

   // quotient fits 32 bits exactly when numerator < divisor * 2^32
   always_comb begin
      logic [NW-1:0] num;
      for (int k = 0; k < NE; k++) begin
         num = {nmag5_ff[k], {(2 * FRAC_BITS){1'b0}}};
         sat6_in[k] = (CW'(num) >= {dmag5_ff, {QW{1'b0}}});
         r06_in[k] = MW'(num[NW-1:QW]);
         nl6_in[k] = num[QW-1:0];
      end
   end

   always_comb begin
      vd_in = {vd_ff[STEPS-2:0], v6_ff};
      sd_in = {sd_ff[STEPS-2:0], sing6_ff};
      dch_in[0] = dmag6_ff;
      for (int s = 1; s < STEPS - 1; s++) begin
         dch_in[s] = dch_ff[s-1];
      end
      dpipe[0] = dmag6_ff;
      for (int s = 1; s < STEPS; s++) begin
         dpipe[s] = dch_ff[s-1];
      end
   end

   for (genvar k = 0; k < NE; k++) begin : g_lane
      nm3_div u_div (
         .clock     (clock),
         .en        (en),
         .r_start   (r06_ff[k]),
         .n_start   (nl6_ff[k]),
         .neg_start (neg6_ff[k]),
         .sat_start (sat6_ff[k]),
         .dpipe     (dpipe),
         .q         (lq[k]),
         .neg       (lneg[k]),
         .sat       (lsat[k])
      );
   end

   always_comb begin
      osing_in = sd_ff[STEPS-1];
      for (int k = 0; k < NE; k++) begin
         if (sd_ff[STEPS-1]) begin
            out_in[k] = '0;
         end else if (lneg[k]) begin
            out_in[k] = (lsat[k] || lq[k] > nm3_pkg::Q_MIN) ? nm3_pkg::Q_MIN : -lq[k];
         end else begin
            out_in[k] = (lsat[k] || lq[k][QW-1]) ? nm3_pkg::Q_MAX : lq[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         vd_ff <= '0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         vd_ff <= vd_in;
         ov_ff <= vd_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cf1_ff <= cf1_in;
         for (int j = 0; j < NR; j++) begin
            el1_ff[j] <= pop_data.el[j];
         end
         cf2_ff <= cf1_ff;
         plo2_ff <= plo2_in;
         phi2_ff <= phi2_in;
         cf3_ff <= cf2_ff;
         t3_ff <= t3_in;
         cf4_ff <= cf3_ff;
         det4_ff <= det4_in;
         sing5_ff <= sing5_in;
         neg5_ff <= neg5_in;
         nmag5_ff <= nmag5_in;
         dmag5_ff <= dmag5_in;
         sing6_ff <= sing5_ff;
         neg6_ff <= neg5_ff;
         sat6_ff <= sat6_in;
         r06_ff <= r06_in;
         nl6_ff <= nl6_in;
         dmag6_ff <= dmag5_ff;
         sd_ff <= sd_in;
         dch_ff <= dch_in;
         osing_ff <= osing_in;
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid = ov_ff;
   assign rsp_ch.singular = osing_ff;
   assign rsp_ch.out_0 = out_ff[0];
   assign rsp_ch.out_1 = out_ff[1];
   assign rsp_ch.out_2 = out_ff[2];
   assign rsp_ch.out_3 = out_ff[3];
   assign rsp_ch.out_4 = out_ff[4];
   assign rsp_ch.out_5 = out_ff[5];
   assign rsp_ch.out_6 = out_ff[6];
   assign rsp_ch.out_7 = out_ff[7];
   assign rsp_ch.out_8 = out_ff[8];

   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && osing_ff) |-> (out_ff[0] == '0 && out_ff[4] == '0 && out_ff[8] == '0))
      else $error("singular transaction with nonzero outputs");

   assert property (@(posedge clock) disable iff (reset)
      (en && v1_ff) |=> v2_ff)
      else $error("item lost between cofactor and partial product stages");

   assert property (@(posedge clock) disable iff (reset)
      (en && vd_ff[STEPS-1]) |=> ov_ff)
      else $error("divider result not captured by output register");

endmodule

FILE: design/normal_matrix_3x3.sv
// Normal matrix unit: takes the upper-left 3x3 of a transform (Q16.16 by
// default, FRAC_BITS fraction bits) on req_ch and returns the transpose of
// its inverse on rsp_ch, one response transaction per request transaction.
// Each output is cofactor / determinant, truncated toward zero and saturated
// to 32 bits; a zero determinant gives all-zero outputs with singular set.
//
// A matrix passes from request accept to response valid through the front
// product register, the queue, six arithmetic stages (cofactors, partial
// products, terms, determinant, magnitudes, range check), 32 stages of the
// restoring dividers (one quotient bit each, nine lanes sharing the divisor
// pipeline) and the output register. One matrix per cycle unless stalled.
//
// When rsp_ch.valid is high and rsp_ch.ready low, the back pipeline and
// output register hold; the two-entry queue and the front register keep
// accepting up to three more requests before req_ch.ready drops. Synchronous
// reset empties the pipeline and queue; no clearing pass is needed.
module normal_matrix_3x3 #(
   parameter int FRAC_BITS = nm3_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   nm3_req_if.sink    req_ch,
   nm3_rsp_if.source  rsp_ch
);

   logic                push_valid;
   nm3_pkg::prod_type   push_data;
   nm3_pkg::prod_type   pop_data;
   nm3_pkg::q_stat_type q_stat;
   logic                pop;

   nm3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_stat     (q_stat),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   nm3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .q_stat     (q_stat),
      .pop_data   (pop_data)
   );

   nm3_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

FILE: verif/nm3_tb_if.sv
`timescale 1ns / 100ps

package nm3_tb_pkg;

   typedef struct {
      logic signed [31:0] m[9];
   } mat_type;

   typedef struct {
      logic signed [31:0] q[9];
      logic               singular;
   } nrm_type;

endpackage

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int FB = nm3_pkg::FRAC_BITS_DEF;
   localparam int STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   nm3_req_if req_ch ();
   nm3_rsp_if rsp_ch ();

   normal_matrix_3x3 u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   nm3_tb_pkg::nrm_type expected_q[$];
   int   n_errors = 0;
   int   n_results = 0;
   int   n_singular = 0;
   int   n_sat = 0;
   int   idle_cycles = 0;
   bit   stim_done = 1'b0;

   // Transpose of inverse: exact cofactors, exact determinant, truncating divide, saturate.
   function automatic nm3_tb_pkg::nrm_type normal_of(nm3_tb_pkg::mat_type mt);
      logic signed [127:0] a, b, c, d, e, f, g, h, i, det, num, quo;
      logic signed [127:0] cof[9];
      nm3_tb_pkg::nrm_type r;
      a = mt.m[0]; b = mt.m[1]; c = mt.m[2];
      d = mt.m[3]; e = mt.m[4]; f = mt.m[5];
      g = mt.m[6]; h = mt.m[7]; i = mt.m[8];
      cof[0] = e*i - f*h; cof[1] = f*g - d*i; cof[2] = d*h - e*g;
      cof[3] = c*h - b*i; cof[4] = a*i - c*g; cof[5] = b*g - a*h;
      cof[6] = b*f - c*e; cof[7] = c*d - a*f; cof[8] = a*e - b*d;
      det = a*cof[0] + b*cof[1] + c*cof[2];
      r.singular = (det == 0);
      for (int k = 0; k < 9; k++) begin
         if (r.singular) begin
            r.q[k] = '0;
         end else begin
            num = cof[k] <<< (2*FB);
            quo = num / det;   // signed divide truncates toward zero
            if (quo > 128'sh7FFF_FFFF) r.q[k] = nm3_pkg::Q_MAX;
            else if (quo < -128'sh8000_0000) r.q[k] = nm3_pkg::Q_MIN;
            else r.q[k] = quo[31:0];
         end
      end
      return r;
   endfunction

   function automatic nm3_tb_pkg::nrm_type fixed_rsp(logic signed [31:0] v, logic sg);
      nm3_tb_pkg::nrm_type r;
      foreach (r.q[k]) r.q[k] = v;
      r.singular = sg;
      return r;
   endfunction

   // directed rows; has_fixed marks rows whose result is typed in
   typedef struct {
      nm3_tb_pkg::mat_type mt;
      bit                  has_fixed;
      nm3_tb_pkg::nrm_type fixed;
   } row_type;

   row_type dir_rows[$];

   function automatic nm3_tb_pkg::mat_type diag(logic signed [31:0] x, logic signed [31:0] y,
                                                logic signed [31:0] z);
      nm3_tb_pkg::mat_type mt;
      foreach (mt.m[k]) mt.m[k] = '0;
      mt.m[0] = x; mt.m[4] = y; mt.m[8] = z;
      return mt;
   endfunction

   function automatic nm3_tb_pkg::mat_type fill(logic signed [31:0] v);
      nm3_tb_pkg::mat_type mt;
      foreach (mt.m[k]) mt.m[k] = v;
      return mt;
   endfunction

   function automatic nm3_tb_pkg::mat_type rand_mat(int mode);
      nm3_tb_pkg::mat_type mt;
      foreach (mt.m[k]) begin
         case (mode)
            0: mt.m[k] = $urandom;
            1: mt.m[k] = $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            2: mt.m[k] = $signed($urandom_range(0, 2047)) - 1024;
            default: mt.m[k] = ($urandom_range(0, 3) == 0) ? 32'sh0 :
                                $signed($urandom_range(0, 8)) - 4 <<< 16;
         endcase
      end
      // occasionally force a dependent row -> singular
      if (mode != 0 && $urandom_range(0, 9) == 0)
         for (int k = 0; k < 3; k++) mt.m[6+k] = mt.m[k];
      return mt;
   endfunction

   task automatic add_row(nm3_tb_pkg::mat_type mt, bit hf, nm3_tb_pkg::nrm_type fx);
      row_type r;
      r.mt = mt; r.has_fixed = hf; r.fixed = fx;
      dir_rows.insert(dir_rows.size(), r);
   endtask

   task automatic send(nm3_tb_pkg::mat_type mt);
      req_ch.valid <= 1'b1;
      req_ch.in_0 <= mt.m[0]; req_ch.in_1 <= mt.m[1]; req_ch.in_2 <= mt.m[2];
      req_ch.in_4 <= mt.m[3]; req_ch.in_5 <= mt.m[4]; req_ch.in_6 <= mt.m[5];
      req_ch.in_8 <= mt.m[6]; req_ch.in_9 <= mt.m[7]; req_ch.in_10 <= mt.m[8];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic idle(int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // sender: bursts with gaps; valid stays high across a burst
   task automatic push(nm3_tb_pkg::mat_type mt, bit hf, nm3_tb_pkg::nrm_type fx,
                       ref int burst);
      if (burst == 0) begin
         idle($urandom_range(1, 6));
         burst = $urandom_range(1, 20);
      end
      send(mt);
      expected_q.insert(expected_q.size(), hf ? fx : normal_of(mt));
      burst--;
      @(negedge clock);
   endtask

   // receiver stall pattern: quiet spells and choppy spells
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (($urandom_range(0, 63) < 6)) rsp_ch.ready <= 1'b1;
      else if ((n_results / 128) % 3 == 0) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
   end

   task automatic cmp(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin
      nm3_tb_pkg::nrm_type ex;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_results++;
         if (expected_q.size() == 0) begin
            $error("response transaction with nothing pending");
            n_errors++;
         end else begin
            ex = expected_q.pop_front();
            if (ex.singular) n_singular++;
            if (ex.q[0] == nm3_pkg::Q_MAX || ex.q[0] == nm3_pkg::Q_MIN) n_sat++;
            cmp("out_0", ex.q[0], rsp_ch.out_0); cmp("out_1", ex.q[1], rsp_ch.out_1);
            cmp("out_2", ex.q[2], rsp_ch.out_2); cmp("out_3", ex.q[3], rsp_ch.out_3);
            cmp("out_4", ex.q[4], rsp_ch.out_4); cmp("out_5", ex.q[5], rsp_ch.out_5);
            cmp("out_6", ex.q[6], rsp_ch.out_6); cmp("out_7", ex.q[7], rsp_ch.out_7);
            cmp("out_8", ex.q[8], rsp_ch.out_8);
            if (ex.singular !== rsp_ch.singular) begin
               $error("singular: expected %0d, got %0d", ex.singular, rsp_ch.singular);
               n_errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         idle_cycles <= 0;
      else if (!stim_done || expected_q.size() != 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      nm3_tb_pkg::mat_type mt;
      nm3_tb_pkg::nrm_type none;
      int   burst;
      int   mode;
      none = fixed_rsp(0, 1'b0);
      req_ch.valid = 1'b0;
      req_ch.in_0 = '0; req_ch.in_1 = '0; req_ch.in_2 = '0;
      req_ch.in_4 = '0; req_ch.in_5 = '0; req_ch.in_6 = '0;
      req_ch.in_8 = '0; req_ch.in_9 = '0; req_ch.in_10 = '0;

      add_row(fill(0), 1'b1, fixed_rsp(0, 1'b1));                 // all-zero: singular
      add_row(fill(32'sh7FFF_FFFF), 1'b1, fixed_rsp(0, 1'b1));    // rank one
      add_row(fill(32'sh8000_0000), 1'b1, fixed_rsp(0, 1'b1));
      add_row(fill(-1), 1'b1, fixed_rsp(0, 1'b1));
      mt = diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);           // identity
      add_row(mt, 1'b0, none);
      add_row(diag(32'sh2_0000, -32'sh4_0000, 32'sh8000), 1'b0, none);
      add_row(diag(1, 1, 1), 1'b0, none);                          // tiny det: saturate
      add_row(diag(-1, 1, 1), 1'b0, none);
      add_row(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 1'b0, none);
      add_row(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 1'b0, none);
      add_row(diag(32'sh8000_0000, 32'sh7FFF_FFFF, -1), 1'b0, none);
      mt = diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);            // singular by zero row
      mt.m[4] = 0;
      add_row(mt, 1'b0, none);
      for (int k = 0; k < 9; k++) begin                            // nonzero entries at k, k+4 and k+8 mod 9
         mt = fill(0);
         mt.m[k] = 32'sh3_0000;
         mt.m[(k + 4) % 9] = -32'sh1_8000;
         mt.m[(k + 8) % 9] = 32'sh7FFF_FFFF;
         add_row(mt, 1'b0, none);
      end
      mt.m[0] = 32'sh5555_5555; mt.m[1] = 32'shAAAA_AAAA; mt.m[2] = 32'sh1234_5678;
      mt.m[3] = 32'shEDCB_A987; mt.m[4] = 32'sh0F0F_0F0F; mt.m[5] = 32'shF0F0_F0F0;
      mt.m[6] = 32'sh0000_0001; mt.m[7] = 32'shFFFF_FFFE; mt.m[8] = 32'sh7F00_00FF;
      add_row(mt, 1'b0, none);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      burst = 0;
      foreach (dir_rows[n]) push(dir_rows[n].mt, dir_rows[n].has_fixed, dir_rows[n].fixed,
                                 burst);
      for (int n = 0; n < 1900; n++) begin
         if (n == 900) begin
            // drain fully before resuming
            idle(1);
            while (expected_q.size() != 0) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         push(rand_mat(mode), 1'b0, none, burst);
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);

      $display("covered %0d matrices: %0d singular, %0d with saturated out_0",
               n_results, n_singular, n_sat);
      if (n_errors == 0 && expected_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/nm3_pkg.sv
design/nm3_if.sv
design/nm3_front.sv
design/nm3_queue.sv
design/nm3_div.sv
design/nm3_back.sv
design/normal_matrix_3x3.sv
verif/nm3_tb_if.sv
verif/tb.sv
